/* hw/rtl/sweep_active_interval_pairing_defines.svh */
// Assertion helpers for the checker file.
`ifndef SWEEP_ACTIVE_INTERVAL_PAIRING_DEFINES_SVH
`define SWEEP_ACTIVE_INTERVAL_PAIRING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SAIP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("saip assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SAIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("saip assertion failed");

`endif

/* hw/rtl/saip_pkg.sv */
`timescale 1ns / 1ps
package saip_pkg;

  localparam int PART_W = 16;
  localparam int KIND_W = 2;
  localparam int GX_W   = 2;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // One open interval.
  typedef struct packed {
    logic [PART_W-1:0] particle;
    logic [GX_W-1:0]   gx;
    logic              crossing;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic              has_pair;
    logic [PART_W-1:0] first;
    logic [PART_W-1:0] second;
    logic [GX_W-1:0]   gx;
    logic              crossing;
    logic              overflow;
    logic              last;
  } result_t;

  // Compare unit verdict for one stored entry.
  typedef struct packed {
    logic              same_part;
    logic              skip;
    logic [PART_W-1:0] first;
    logic [PART_W-1:0] second;
    logic [GX_W-1:0]   gx;
    logic              crossing;
  } cmp_t;

endpackage

/* hw/rtl/saip_mem.sv */
`timescale 1ns / 1ps
module saip_mem #(
  parameter int ACTIVE_DEPTH = 32,
  parameter int AW           = 5
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output saip_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  saip_pkg::entry_t  wr_data
);
  import saip_pkg::*;

  entry_t mem_r [ACTIVE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/saip_cmp.sv */
`timescale 1ns / 1ps
module saip_cmp (
  input  saip_pkg::entry_t item,
  input  saip_pkg::entry_t stored,
  output saip_pkg::cmp_t   verdict
);
  import saip_pkg::*;

  logic swap;

  // stored entry with a nonzero image offset leads the pair
  assign swap = (stored.gx != '0);

  always_comb begin
    verdict.same_part = (stored.particle == item.particle);
    verdict.skip      = verdict.same_part || (swap && (stored.gx == item.gx));
    verdict.first     = swap ? stored.particle : item.particle;
    verdict.second    = swap ? item.particle : stored.particle;
    verdict.gx        = swap ? stored.gx : item.gx;
    verdict.crossing  = stored.crossing | item.crossing;
  end

endmodule

/* hw/rtl/saip_seq.sv */
`timescale 1ns / 1ps
module saip_seq #(
  parameter int ACTIVE_DEPTH = 32,
  parameter int AW           = 5,
  parameter int CW           = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [saip_pkg::KIND_W-1:0]  in_kind,
  input  saip_pkg::entry_t             in_item,
  output saip_pkg::entry_t             item,
  input  saip_pkg::cmp_t               verdict,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  saip_pkg::entry_t             rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output saip_pkg::entry_t             wr_data,
  input  logic                         slot_free,
  output logic                         push,
  output saip_pkg::result_t            push_res
);
  import saip_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  entry_t            item_r, item_nxt;
  logic              ov_r, ov_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic              pend_v_r, pend_v_nxt;
  result_t           pend_r, pend_nxt;
  result_t           new_pair;
  logic              k_last;
  logic              full;

  assign in_ready = (state_r == S_IDLE);
  assign item     = item_r;
  assign k_last   = (CW'(k_r) == (count_r - 1'b1));
  assign full     = (count_r >= CW'(ACTIVE_DEPTH));

  always_comb begin
    new_pair          = '0;
    new_pair.has_pair = 1'b1;
    new_pair.first    = verdict.first;
    new_pair.second   = verdict.second;
    new_pair.gx       = verdict.gx;
    new_pair.crossing = verdict.crossing;
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    item_nxt   = item_r;
    ov_nxt     = ov_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = rd_data;
    push       = 1'b0;
    push_res   = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          item_nxt   = in_item;
          ov_nxt     = 1'b0;
          pend_v_nxt = 1'b0;
          k_nxt      = '0;
          state_nxt  = S_FIN;
          unique case (in_kind)
            KIND_START: begin
              if (full) begin
                ov_nxt = 1'b1;
              end else if (count_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_WALK;
              end
            end
            KIND_END: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_FIND;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        // a new pair must first flush the held one
        if (verdict.skip || !pend_v_r || slot_free) begin
          if (!verdict.skip) begin
            push       = pend_v_r;
            pend_nxt   = new_pair;
            pend_v_nxt = 1'b1;
          end
          if (k_last) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt   = k_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = k_r + 1'b1;
          end
        end
      end
      S_FIND: begin
        if (verdict.same_part) begin
          j_nxt     = k_r;
          rd_en     = 1'b1;
          rd_addr   = AW'(count_r - 1'b1);
          state_nxt = S_MOVE;
        end else if (k_last) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt   = k_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = k_r + 1'b1;
        end
      end
      S_MOVE: begin
        // tail entry fills the hole
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = rd_data;
        count_nxt = count_r - 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          push = 1'b1;
          if (pend_v_r) begin
            push_res      = pend_r;
            push_res.last = 1'b1;
          end else begin
            push_res          = '0;
            push_res.overflow = ov_r;
            push_res.last     = 1'b1;
          end
          pend_v_nxt = 1'b0;
          if ((kind_r == KIND_START) && !ov_r) begin
            wr_en     = 1'b1;
            wr_addr   = AW'(count_r);
            wr_data   = item_r;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    item_r <= item_nxt;
    ov_r   <= ov_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    pend_r <= pend_nxt;
  end

endmodule

/* hw/rtl/sweep_active_interval_pairing.sv */
// A start walks the open intervals one entry at a time and gives a result for each pair;
//   an end searches the list for its particle; clear and dropped starts give one result, no pair.
// One item is in flight at a time: a new item is accepted only after the last one's final
//   result is pushed, as the active-list memory has one read port.
// Reset (rst_n low, synchronous): list emptied, sequencer idle, output beat dropped;
//   stored entries are not cleared, so there is no clearing pass.
`timescale 1ns / 1ps
module sweep_active_interval_pairing #(
  parameter int ACTIVE_DEPTH  = 32,
  parameter int PARTICLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] particle, [17:16] ghost_x, [18] crossing, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] first_particle, [31:16] second_particle,
                                  // [33:32] pair_ghost_x, [34] pair_crossing, rest zero
  output logic [1:0]  out_tuser,  // [0] has_pair, [1] overflow
  output logic        out_tlast   // last
);
  import saip_pkg::*;

  localparam int AW = $clog2(ACTIVE_DEPTH);
  localparam int CW = $clog2(ACTIVE_DEPTH + 1);
  // ids keep only their low PARTICLE_BITS bits
  localparam logic [PART_W-1:0] PMASK = (PARTICLE_BITS >= PART_W) ? {PART_W{1'b1}} :
                                        PART_W'((64'd1 << PARTICLE_BITS) - 64'd1);

  entry_t          in_item;
  entry_t          item;
  entry_t          rd_data;
  entry_t          wr_data;
  cmp_t            verdict;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            slot_free;
  logic            push;
  result_t         push_res;
  logic            out_v_r;
  result_t         out_r;

  always_comb begin
    in_item.particle = in_tdata[15:0] & PMASK;
    in_item.gx       = in_tdata[17:16];
    in_item.crossing = in_tdata[18];
  end

  // Sequencer: accept, walk the list, hold back one pair so the
  // final one can carry last.
  saip_seq #(
    .ACTIVE_DEPTH (ACTIVE_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_item   (in_item),
    .item      (item),
    .verdict   (verdict),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .slot_free (slot_free),
    .push      (push),
    .push_res  (push_res)
  );

  // Active list, registered read.
  saip_mem #(
    .ACTIVE_DEPTH (ACTIVE_DEPTH),
    .AW           (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Shared compare unit: pairing rule for walks, id match for end search.
  saip_cmp u_cmp (
    .item    (item),
    .stored  (rd_data),
    .verdict (verdict)
  );

  // Output register; refills in the cycle the held beat drains.
  assign slot_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_r.crossing, out_r.gx, out_r.second, out_r.first};
  assign out_tuser  = {out_r.overflow, out_r.has_pair};
  assign out_tlast  = out_r.last;

endmodule

/* hw/rtl/saip_checker.sv */
`timescale 1ns / 1ps
`include "sweep_active_interval_pairing_defines.svh"
module saip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled beat holds
  `SAIP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // one item in flight at a time
  `SAIP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // pairs never flag overflow
  `SAIP_ASSERT_IMPL(a_pair_no_ovf, out_tvalid && out_tuser[0], !out_tuser[1])

  // an empty result is alone, so it closes its item with zero payload
  `SAIP_ASSERT_IMPL(a_empty_last, out_tvalid && !out_tuser[0], out_tlast && (out_tdata == 40'd0))

endmodule

bind sweep_active_interval_pairing saip_checker u_saip_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import saip_pkg::*;

  localparam int ACTIVE_DEPTH = 32;
  // Kind code that is no start, end or clear; the block answers it with an empty result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Length of the forced output back-pressure window, in cycles.
  localparam int LONG_HOLD_CYCLES = 400;
  // Random items per idling phase.
  localparam int PHASE_ITEMS = 90;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the open-interval list and predicts
  // the result beats of every accepted event; checks results in order.
  // ---------------------------------------------------------------------------
  class pair_scoreboard;
    entry_t      open_list[ACTIVE_DEPTH];
    int unsigned open_count;
    result_t     pending_results[$];
    int unsigned mismatches;

    function new();
      open_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Called once per accepted input beat.
    function void note_event(logic [KIND_W-1:0] kind, logic [PART_W-1:0] part,
                             logic [GX_W-1:0] gx, logic cr);
      result_t held;
      bit      have_held;
      bit      dropped;
      int      k;
      entry_t  e;
      have_held = 0;
      dropped   = 0;
      held      = '0;
      case (kind)
        KIND_START: begin
          if (open_count >= ACTIVE_DEPTH) begin
            dropped = 1;
          end else begin
            for (k = 0; k < open_count; k++) begin
              e = open_list[k];
              if (e.particle == part) continue;
              // same nonzero image offset on both sides: nothing to test
              if (e.gx != '0 && e.gx == gx) continue;
              if (have_held) pending_results.push_back(held);
              held = '0;
              held.has_pair = 1'b1;
              held.crossing = e.crossing | cr;
              if (e.gx == '0) begin
                held.first  = part;
                held.second = e.particle;
                held.gx     = gx;
              end else begin
                // stored entry carries the offset: swap order, use its offset
                held.first  = e.particle;
                held.second = part;
                held.gx     = e.gx;
              end
              have_held = 1;
            end
            open_list[open_count] = '{particle: part, gx: gx, crossing: cr};
            open_count++;
          end
        end
        KIND_END: begin
          for (k = 0; k < open_count; k++) begin
            if (open_list[k].particle == part) begin
              open_count--;
              open_list[k] = open_list[open_count];
              break;
            end
          end
        end
        KIND_CLEAR: open_count = 0;
        default: ;
      endcase
      if (!have_held) begin
        held = '0;
        held.overflow = dropped;
      end
      held.last = 1'b1;
      pending_results.push_back(held);
    endfunction

    // Called once per accepted output beat.
    function void check_beat(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat pair=%0b %h/%h gx=%0d cr=%0b ov=%0b last=%0b",
                   $time, got.has_pair, got.first, got.second, got.gx, got.crossing,
                   got.overflow, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected pair=%0b %h/%h gx=%0d cr=%0b ov=%0b last=%0b",
                   want.has_pair, want.first, want.second, want.gx, want.crossing,
                   want.overflow, want.last);
          $display("  actual   pair=%0b %h/%h gx=%0d cr=%0b ov=%0b last=%0b",
                   got.has_pair, got.first, got.second, got.gx, got.crossing,
                   got.overflow, got.last);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [15:0] particle, [17:16] ghost_x, [18] crossing
  logic [1:0]  in_tuser   = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [15:0] first, [31:16] second, [33:32] gx, [34] crossing
  logic [1:0]  out_tuser;         // [0] has_pair, [1] overflow
  logic        out_tlast;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sweep_active_interval_pairing #(
    .ACTIVE_DEPTH (ACTIVE_DEPTH),
    .PARTICLE_BITS(PART_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  pair_scoreboard sb = new();

  // Idle knobs, percent of cycles; changed per phase by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // One-shot request for a long output hold-off; consumed by the receiver.
  bit long_hold_req  = 0;

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD_CYCLES;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Output monitor: every accepted result beat goes to the scoreboard.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_beat('{has_pair: out_tuser[0], first: out_tdata[15:0],
                        second: out_tdata[31:16], gx: out_tdata[33:32],
                        crossing: out_tdata[34], overflow: out_tuser[1], last: out_tlast});
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one event beat, with random idle cycles first; returns on accept.
  task automatic offer_event(logic [KIND_W-1:0] kind, logic [PART_W-1:0] part,
                             logic [GX_W-1:0] gx, logic cr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, cr, gx, part};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_event(kind, part, gx, cr);
  endtask

  // Sender goes quiet until every predicted beat has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Zero offsets most often, some +1/-1, now and then the out-of-range pattern.
  function automatic logic [GX_W-1:0] pick_gx();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 2'd0;
    if (r < 7) return 2'd1;
    if (r < 9) return 2'd3;
    return 2'd2;
  endfunction

  // Clear, then overfill the list so starts get dropped, then a few ends.
  task automatic fill_sweep(inout int count);
    logic [PART_W-1:0] opened[$];
    logic [PART_W-1:0] p;
    int                i;
    int                j;
    offer_event(KIND_CLEAR, PART_W'($urandom), 2'd0, 1'b0);
    count++;
    for (i = 0; i < ACTIVE_DEPTH + 2; i++) begin
      p = PART_W'($urandom);
      opened.push_back(p);
      offer_event(KIND_START, p, pick_gx(), 1'($urandom));
      count++;
    end
    for (i = 0; i < 5; i++) begin
      j = $urandom_range(0, ACTIVE_DEPTH - 1 - i);
      offer_event(KIND_END, opened[j], pick_gx(), 1'($urandom));
      opened.delete(j);
      count++;
    end
  endtask

  // Well-formed sweep: clear, then starts and ends over a small particle pool
  // so that same-particle skips and end hits are common.
  task automatic random_sweep(inout int count);
    logic [PART_W-1:0] pool[8];
    logic [PART_W-1:0] opened[$];
    logic [PART_W-1:0] p;
    int                pool_used;
    int                len;
    int                i;
    int                j;
    foreach (pool[i]) pool[i] = PART_W'($urandom);
    pool_used = $urandom_range(2, 8);
    len       = $urandom_range(2, 24);
    offer_event(KIND_CLEAR, PART_W'($urandom), pick_gx(), 1'($urandom));
    count++;
    for (i = 0; i < len; i++) begin
      if (opened.size() > 0 && $urandom_range(0, 2) == 0) begin
        j = $urandom_range(0, opened.size() - 1);
        p = opened[j];
        opened.delete(j);
        offer_event(KIND_END, p, pick_gx(), 1'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        // end for something that is likely not open
        offer_event(KIND_END, PART_W'($urandom), pick_gx(), 1'($urandom));
      end else begin
        p = pool[$urandom_range(0, pool_used - 1)];
        opened.push_back(p);
        offer_event(KIND_START, p, pick_gx(), 1'($urandom));
      end
      count++;
    end
  endtask

  // Unstructured event, any kind including the unused one.
  task automatic noise_event(inout int count);
    logic [KIND_W-1:0] kind;
    kind = KIND_W'($urandom_range(0, 3));
    offer_event(kind, PART_W'($urandom), GX_W'($urandom), 1'($urandom));
    if (kind != KIND_UNUSED) count++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list events, pairing order and skip rules, the
    // out-of-range offset, end with swap-in, end with no match, unused kind.
    offer_event(KIND_CLEAR,  16'h0000, 2'd0, 1'b0);
    offer_event(KIND_END,    16'h0000, 2'd0, 1'b0);  // nothing open
    offer_event(KIND_UNUSED, 16'h0000, 2'd0, 1'b0);
    offer_event(KIND_START,  16'h0000, 2'd0, 1'b0);  // first entry, no pair
    offer_event(KIND_START,  16'hFFFF, 2'd0, 1'b1);
    offer_event(KIND_START,  16'h0000, 2'd1, 1'b0);  // skips its own particle
    offer_event(KIND_START,  16'h1234, 2'd1, 1'b0);  // skips equal nonzero offset
    offer_event(KIND_START,  16'h5555, 2'd3, 1'b1);  // stored offset wins, swapped
    offer_event(KIND_START,  16'hAAAA, 2'd2, 1'b0);  // pattern -2 as an offset
    offer_event(KIND_START,  16'h7777, 2'd2, 1'b1);
    offer_event(KIND_END,    16'h0000, 2'd0, 1'b0);  // last entry moved into slot 0
    offer_event(KIND_END,    16'h9999, 2'd3, 1'b1);  // no match
    offer_event(KIND_START,  16'h8001, 2'd0, 1'b0);
    offer_event(KIND_END,    16'hFFFF, 2'd0, 1'b0);
    offer_event(KIND_END,    16'h0000, 2'd1, 1'b0);  // second open one of 0x0000
    offer_event(KIND_UNUSED, 16'hFFFF, 2'd3, 1'b1);
    offer_event(KIND_CLEAR,  16'hFFFF, 2'd3, 1'b1);
    offer_event(KIND_START,  16'h4242, 2'd0, 1'b1);
    offer_event(KIND_START,  16'h4242, 2'd1, 1'b0);  // all same particle
    offer_event(KIND_START,  16'h4242, 2'd3, 1'b1);
    offer_event(KIND_START,  16'hBEEF, 2'd3, 1'b0);
    offer_event(KIND_CLEAR,  16'h0000, 2'd0, 1'b0);

    // Random part in four idling phases; each starts with an overfilled
    // sweep, and the sender drains before every phase change.
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      count = 0;
      // no-idle phase: hold the output off while the list fills up, so the
      // block backs up into its input
      if (phase == 0) long_hold_req = 1;
      fill_sweep(count);
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) noise_event(count);
        else random_sweep(count);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
